@@ rtl/msbb_pkg.sv @@
// Shared types, constants and helper functions of the bit stream buffer.
package msbb_pkg;

    localparam int BUFFER_BYTES = 256;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int CAP_BITS     = BUFFER_BYTES * 8;
    // Fill position in bits; it must hold the capacity itself.
    localparam int POS_W        = ADDR_W + 4;
    localparam int START_W      = 11;
    localparam int SUM_W        = ((POS_W > START_W) ? POS_W : START_W) + 1;

    // A field of up to 32 bits at any bit offset spans at most five bytes.
    localparam int WIN_BYTES    = 5;
    localparam int WIN_W        = WIN_BYTES * 8;
    localparam logic [2:0] LAST_STEP = 3'(WIN_BYTES);

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_REWIND = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_BEYOND   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MASK,
        S_ACCESS,
        S_EXTRACT,
        S_DONE
    } state_t;

    typedef enum logic {
        SHIFT_UP,
        SHIFT_DOWN
    } shift_dir_t;

    typedef logic [WIN_BYTES-1:0][7:0] win_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
    } store_req_t;

    function automatic logic [5:0] clamp_count(input logic [5:0] raw);
        return (raw > 6'd32) ? 6'd32 : raw;
    endfunction

    // Ones in the low n bit positions, for n from 0 to 32.
    function automatic logic [31:0] low_mask(input logic [5:0] n);
        logic [31:0] m;
        for (int i = 0; i < 32; i++)
        begin
            m[i] = (6'(i) < n);
        end
        return m;
    endfunction

endpackage

@@ rtl/msbb_shift.sv @@
// Shared barrel shifter used for field alignment, mask building and extraction.
module msbb_shift (
    input  logic [msbb_pkg::WIN_W-1:0] din,
    input  logic [5:0]                 amount,
    input  msbb_pkg::shift_dir_t       dir,
    output logic [msbb_pkg::WIN_W-1:0] dout
);
    import msbb_pkg::*;

    always_comb
    begin
        case (dir)
            SHIFT_UP:   dout = din << amount;
            SHIFT_DOWN: dout = din >> amount;
            default:    dout = din;
        endcase
    end

endmodule

@@ rtl/msbb_store.sv @@
// Byte store with one read and one write port; bytes never written read as zero.
module msbb_store (
    input  logic                 clk,
    input  logic                 rst_n,
    input  msbb_pkg::store_req_t req,
    output logic [7:0]           rd_data
);
    import msbb_pkg::*;

    logic [7:0]              mem_array [BUFFER_BYTES];
    logic [BUFFER_BYTES-1:0] valid_reg;
    logic [7:0]              rd_word_reg;
    logic                    rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_array[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_word_reg <= mem_array[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_hit_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_word_reg : 8'd0;

endmodule

@@ rtl/msb_first_bitstream_buffer.sv @@
// Top level of the MSB-first bit stream buffer: sequencer, datapath and assertions.
//
// Usage: drive mode, bit_count, field_value and start_position and raise start
// while busy is low; the command is taken at that clock edge and busy rises.
// Exactly one result beat follows: read_data, fill_level and status are valid
// in the single cycle in which done is high, and busy falls in the next cycle.
// The receiver cannot stall the block; it must take the beat when done is high.
//
// Sequencing: a command walks over the five stored bytes of the window that
// holds its field, one byte per cycle through the byte store, with a
// read-modify-write overlap for appends. Appends pass through CHECK, MASK,
// ACCESS and DONE; reads through CHECK, ACCESS, EXTRACT and DONE. Rewind,
// rejected and unused commands go from CHECK straight to DONE. A new command
// is taken only after the result beat, once busy is low. One shared barrel
// shifter aligns the field, builds the write mask and extracts read data.
//
// Reset clears the fill position and the sequencer. The store reads as all
// zero after reset through per-byte valid bits, so no clearing pass is needed.
module msb_first_bitstream_buffer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [5:0]  bit_count,
    input  logic [31:0] field_value,
    input  logic [10:0] start_position,
    output logic        done,
    output logic [31:0] read_data,
    output logic [11:0] fill_level,
    output logic [1:0]  status
);
    import msbb_pkg::*;

    state_t              state_reg, state_next;
    logic [2:0]          step_reg, step_next;
    logic [POS_W-1:0]    wp_reg, wp_next;
    logic [1:0]          mode_reg, mode_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [31:0]         value_reg, value_next;
    logic [START_W-1:0]  pos_reg, pos_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [5:0]          sh_reg, sh_next;
    win_t                data_reg, data_next;
    win_t                mask_reg, mask_next;
    logic [31:0]         read_data_reg, read_data_next;
    logic [1:0]          status_reg, status_next;

    logic [WIN_W-1:0]    shift_din, shift_dout;
    logic [5:0]          shift_amt;
    shift_dir_t          shift_dir;
    store_req_t          store_req;
    logic [7:0]          store_rd;

    logic [2:0]          offset;
    logic [5:0]          sh_calc;
    logic                ovf_append, ovf_read;
    logic [SUM_W-1:0]    pos_wide;
    logic [POS_W+11:0]   fill_wide;

    msbb_shift u_shift (
        .din    (shift_din),
        .amount (shift_amt),
        .dir    (shift_dir),
        .dout   (shift_dout)
    );

    msbb_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .rd_data (store_rd)
    );

    assign offset     = (mode_reg == MODE_APPEND) ? wp_reg[2:0] : pos_reg[2:0];
    assign sh_calc    = 6'(WIN_W) - {3'd0, offset} - cnt_reg;
    assign ovf_append = ({1'b0, wp_reg} + (POS_W+1)'(cnt_reg)) > (POS_W+1)'(CAP_BITS);
    assign ovf_read   = (SUM_W'(pos_reg) + SUM_W'(cnt_reg)) > SUM_W'(CAP_BITS);
    assign pos_wide   = SUM_W'(pos_reg);
    assign fill_wide  = {12'd0, wp_reg};

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                case (mode_reg)
                    MODE_APPEND: state_next = ovf_append ? S_DONE : S_MASK;
                    MODE_READ:   state_next = ovf_read ? S_DONE : S_ACCESS;
                    default:     state_next = S_DONE;
                endcase
            end
            S_MASK:
            begin
                state_next = S_ACCESS;
            end
            S_ACCESS:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = (mode_reg == MODE_APPEND) ? S_DONE : S_EXTRACT;
                end
            end
            S_EXTRACT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and store control for each sequencer state.
    always_comb
    begin
        logic [2:0] byte_idx;
        logic [2:0] byte_sel;
        logic [7:0] mbyte;

        step_next      = step_reg;
        wp_next        = wp_reg;
        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        value_next     = value_reg;
        pos_next       = pos_reg;
        base_next      = base_reg;
        sh_next        = sh_reg;
        data_next      = data_reg;
        mask_next      = mask_reg;
        read_data_next = read_data_reg;
        status_next    = status_reg;

        shift_din = {8'd0, value_reg};
        shift_amt = sh_calc;
        shift_dir = SHIFT_UP;
        store_req = '0;

        byte_idx = step_reg - 3'd1;
        byte_sel = 3'(WIN_BYTES - 1) - byte_idx;
        mbyte    = mask_reg[byte_sel];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next  = mode;
                    cnt_next   = clamp_count(bit_count);
                    value_next = field_value;
                    pos_next   = start_position;
                end
            end
            S_CHECK:
            begin
                sh_next        = sh_calc;
                step_next      = 3'd0;
                read_data_next = 32'd0;
                status_next    = STATUS_OK;
                case (mode_reg)
                    MODE_APPEND:
                    begin
                        if (ovf_append)
                        begin
                            status_next = STATUS_OVERFLOW;
                        end
                        else
                        begin
                            base_next = wp_reg[ADDR_W+2:3];
                            wp_next   = wp_reg + POS_W'(cnt_reg);
                            data_next = shift_dout;
                        end
                    end
                    MODE_READ:
                    begin
                        if (ovf_read)
                        begin
                            status_next = STATUS_BEYOND;
                        end
                        else
                        begin
                            base_next = pos_wide[ADDR_W+2:3];
                        end
                    end
                    MODE_REWIND:
                    begin
                        wp_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_MASK:
            begin
                shift_din = {8'd0, low_mask(cnt_reg)};
                shift_amt = sh_reg;
                mask_next = shift_dout;
            end
            S_ACCESS:
            begin
                step_next         = step_reg + 3'd1;
                store_req.rd_en   = (step_reg != LAST_STEP);
                store_req.rd_addr = base_reg + ADDR_W'(step_reg);
                // The byte read in the previous cycle is merged or captured now.
                if (step_reg != 3'd0)
                begin
                    if (mode_reg == MODE_APPEND)
                    begin
                        store_req.wr_en   = (mbyte != 8'd0);
                        store_req.wr_addr = base_reg + ADDR_W'(byte_idx);
                        store_req.wr_data = (store_rd & ~mbyte) | (data_reg[byte_sel] & mbyte);
                    end
                    else
                    begin
                        data_next[byte_sel] = store_rd;
                    end
                end
            end
            S_EXTRACT:
            begin
                shift_din      = data_reg;
                shift_amt      = sh_reg;
                shift_dir      = SHIFT_DOWN;
                read_data_next = shift_dout[31:0] & low_mask(cnt_reg);
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 3'd0;
            wp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            wp_reg    <= wp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        cnt_reg       <= cnt_next;
        value_reg     <= value_next;
        pos_reg       <= pos_next;
        base_reg      <= base_next;
        sh_reg        <= sh_next;
        data_reg      <= data_next;
        mask_reg      <= mask_next;
        read_data_reg <= read_data_next;
        status_reg    <= status_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = (state_reg == S_DONE);
    assign read_data  = read_data_reg;
    assign status     = status_reg;
    assign fill_level = fill_wide[11:0];

    // The store is only written while an append walks over its bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        store_req.wr_en |-> (state_reg == S_ACCESS) && (mode_reg == MODE_APPEND))
        else $error("store written outside an append");

    // The fill position never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, wp_reg} <= (POS_W+1)'(CAP_BITS))
        else $error("fill position beyond capacity");

    // A result beat is followed by a free cycle for the next command.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy held after a result beat");

    // A rejected command never returns data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STATUS_OK)) |-> (read_data == 32'd0))
        else $error("data returned with an error status");

endmodule
